// ===== hw/rtl/gradient_norm_clip_core_defines.svh =====
// Assertion macros shared by the gradient norm clip RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef GRADIENT_NORM_CLIP_CORE_DEFINES_SVH
`define GRADIENT_NORM_CLIP_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define GNC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define GNC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/gnc_pkg.sv =====
// Shared constants, types and state encodings for the gradient norm clip block.
// No dependencies.
package gnc_pkg;

	// Element buffer
	localparam int unsigned MAX_ELEMENTS = 64;
	localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);

	// Field and datapath widths
	localparam int unsigned GRAD_W  = 16;
	localparam int unsigned NORM_W  = 24;
	localparam int unsigned SQ_W    = 2 * GRAD_W;
	localparam int unsigned SUM_W   = 37;
	localparam int unsigned ROOT_W  = (SUM_W + 1) / 2;
	localparam int unsigned RAD_W   = 2 * ROOT_W;
	localparam int unsigned REM_W   = ROOT_W + 2;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned PROD_W  = GRAD_W + SCALE_W;
	localparam int unsigned CALC_CNT_W = $clog2(ROOT_W);

	// Threshold after reset: 1.0 in Q12.12
	localparam logic [NORM_W-1:0] THR_RST = NORM_W'(4096);

	// Top level sequencer
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FLUSH,
		ST_START,
		ST_WAIT,
		ST_RD,
		ST_LD
	} gnc_state_t;

	// Norm and scale unit sequencer
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SQRT,
		CS_CMP,
		CS_DIV
	} gnc_calc_state_t;

	// Result of the norm and scale unit
	typedef struct packed {
		logic               done;
		logic               clip;
		logic [SCALE_W-1:0] scale;
	} gnc_calc_stat_t;

endpackage

// ===== hw/rtl/gnc_norm_scale.sv =====
// Bit-serial square root of the sum of squares, then bit-serial division
// threshold * 2^16 / norm when the norm exceeds the threshold. Uses gnc_pkg.
`include "gradient_norm_clip_core_defines.svh"

module gnc_norm_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gnc_pkg::SUM_W-1:0]     sum,
	input  logic [gnc_pkg::NORM_W-1:0]    thr,
	output gnc_pkg::gnc_calc_stat_t       stat
);
	import gnc_pkg::*;

	gnc_calc_state_t        cs_q, cs_nx;
	logic [RAD_W-1:0]       rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [ROOT_W-1:0]      root_q;
	logic [SCALE_W-1:0]     quo_q;
	logic [CALC_CNT_W-1:0]  cnt_q;
	logic                   clip_q;
	logic                   done_q;

	logic                   load_en, sqrt_en, cmp_en, div_en;
	logic                   sqrt_last, div_last, clip_nx;
	logic [REM_W+1:0]       sq_work, sq_trial;
	logic [REM_W-1:0]       dv_work, dv_norm;

	assign sqrt_last = (cnt_q == CALC_CNT_W'(ROOT_W - 1));
	assign div_last  = (cnt_q == CALC_CNT_W'(SCALE_W - 1));
	assign clip_nx   = (NORM_W'(root_q) > thr);

	// One root digit: bring down two radicand bits, try (root << 2) | 1
	assign sq_work  = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_trial = (REM_W + 2)'({root_q, 2'b01});

	// One quotient bit: the dividend's low bits are all zero
	assign dv_work = {rem_q[REM_W-2:0], 1'b0};
	assign dv_norm = REM_W'(root_q);

	// Next state
	always_comb begin
		cs_nx = cs_q;
		unique case (cs_q)
			CS_IDLE: if (start) cs_nx = CS_SQRT;
			CS_SQRT: if (sqrt_last) cs_nx = CS_CMP;
			CS_CMP:  cs_nx = clip_nx ? CS_DIV : CS_IDLE;
			CS_DIV:  if (div_last) cs_nx = CS_IDLE;
			default: cs_nx = CS_IDLE;
		endcase
	end

	// Step enables
	always_comb begin
		load_en = 1'b0;
		sqrt_en = 1'b0;
		cmp_en  = 1'b0;
		div_en  = 1'b0;
		unique case (cs_q)
			CS_IDLE: load_en = start;
			CS_SQRT: sqrt_en = 1'b1;
			CS_CMP:  cmp_en  = 1'b1;
			CS_DIV:  div_en  = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q   <= CS_IDLE;
			cnt_q  <= '0;
			clip_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			cs_q   <= cs_nx;
			done_q <= (cmp_en && !clip_nx) || (div_en && div_last);
			if (load_en || cmp_en || (sqrt_en && sqrt_last)) begin
				cnt_q <= '0;
			end else if (sqrt_en || div_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmp_en) begin
				clip_q <= clip_nx;
			end
		end
	end

	// Shift registers of the root and the quotient
	always_ff @(posedge clk) begin
		if (load_en) begin
			rad_q  <= RAD_W'(sum);
			rem_q  <= '0;
			root_q <= '0;
		end else if (sqrt_en) begin
			rad_q <= rad_q << 2;
			if (sq_work >= sq_trial) begin
				rem_q  <= REM_W'(sq_work - sq_trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(sq_work);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end else if (cmp_en) begin
			// the threshold is below the norm whenever the division runs
			rem_q <= REM_W'(thr[ROOT_W-1:0]);
			quo_q <= '0;
		end else if (div_en) begin
			if (dv_work >= dv_norm) begin
				rem_q <= dv_work - dv_norm;
				quo_q <= {quo_q[SCALE_W-2:0], 1'b1};
			end else begin
				rem_q <= dv_work;
				quo_q <= {quo_q[SCALE_W-2:0], 1'b0};
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.clip  = clip_q;
	assign stat.scale = quo_q;

	`GNC_ASSERT(a_start_idle, (start |-> (cs_q == CS_IDLE)), "start while unit busy")
	`GNC_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")
	`GNC_ASSERT(a_div_rem, ((cs_q == CS_DIV) |-> (rem_q < dv_norm)), "division remainder not below norm")

endmodule

// ===== hw/rtl/gradient_norm_clip_core.sv =====
// Top level of the gradient clip block: element buffer, sum of squares and
// emission sequencer. Uses gnc_pkg and gnc_norm_scale.
//
// Usage:
//   Input channel (in_valid/in_ready, grad_in, last_in) takes one beat per
//   cycle while a set loads. A set ends on the beat with last_in high, or on
//   the beat that fills the 64-entry buffer.
//   The norm is then found by a bit-serial square root, and when
//   it exceeds the threshold the scale by a bit-serial divide.
//   in_ready stays low until the last beat of the set is in the output
//   register. Output channel (out_valid/out_ready, grad_out, last_out,
//   clipped) gives the set in arrival order; each beat is a registered
//   buffer read, then an output register load.
//   When the receiver stalls, the output register holds its beat and the
//   emission waits; once the last beat is in the output register the next
//   set may start loading.
//   cfg_we writes the clip threshold from cfg_wdata; do so only while idle.
//   Reset (arst_n low) empties the set, drops any pending output beat and
//   sets the threshold to 1.0. Buffer contents are not cleared.
`include "gradient_norm_clip_core_defines.svh"

module gradient_norm_clip_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gnc_pkg::NORM_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [gnc_pkg::GRAD_W-1:0]  grad_in,
	input  logic                               last_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [gnc_pkg::GRAD_W-1:0]  grad_out,
	output logic                               last_out,
	output logic                               clipped
);
	import gnc_pkg::*;

	gnc_state_t           state_q, state_nx;
	logic [NORM_W-1:0]    thr_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    rd_idx_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]      sq_s1;
	logic                 sq_vld_s1;
	logic [GRAD_W-1:0]    mem [MAX_ELEMENTS];
	logic [GRAD_W-1:0]    rdata_q;
	logic                 out_valid_q;
	logic [GRAD_W-1:0]    grad_q;
	logic                 last_q;
	logic                 clip_q;

	gnc_calc_stat_t       calc_stat;
	logic                 calc_start, sum_clr, emit_load, emit_last, slot_free;
	logic                 in_acc, end_set;
	logic [GRAD_W-1:0]    in_raw, in_mag;
	logic                 rd_neg;
	logic [GRAD_W-1:0]    rd_mag, prod_hi, scaled;
	logic [PROD_W-1:0]    prod;

	assign in_acc    = in_valid && in_ready;
	assign end_set   = last_in || (count_q == CNT_W'(MAX_ELEMENTS - 1));
	assign slot_free = !out_valid_q || out_ready;
	assign emit_last = ((CNT_W'(rd_idx_q) + 1'b1) == count_q);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_acc && end_set) state_nx = ST_FLUSH;
			ST_FLUSH: state_nx = ST_START;
			ST_START: state_nx = ST_WAIT;
			ST_WAIT:  if (calc_stat.done) state_nx = ST_RD;
			ST_RD:    state_nx = ST_LD;
			ST_LD:    if (slot_free) state_nx = emit_last ? ST_LOAD : ST_RD;
			default:  state_nx = ST_LOAD;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		calc_start = 1'b0;
		sum_clr    = 1'b0;
		emit_load  = 1'b0;
		unique case (state_q)
			ST_LOAD:  in_ready = 1'b1;
			ST_START: begin
				calc_start = 1'b1;
				sum_clr    = 1'b1;
			end
			ST_LD:    emit_load = slot_free;
			default:  ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			thr_q       <= THR_RST;
			count_q     <= '0;
			rd_idx_q    <= '0;
			sq_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			sq_vld_s1 <= in_acc;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (in_acc) begin
				count_q <= count_q + 1'b1;
			end else if (emit_load && emit_last) begin
				count_q <= '0;
			end
			if (emit_load) begin
				rd_idx_q <= emit_last ? '0 : rd_idx_q + 1'b1;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Square of the incoming element, then accumulate
	assign in_raw = $unsigned(grad_in);
	assign in_mag = in_raw[GRAD_W-1] ? (~in_raw + 1'b1) : in_raw;

	always_ff @(posedge clk) begin
		sq_s1 <= in_mag * in_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (sum_clr) begin
			sum_q <= '0;
		end else if (sq_vld_s1) begin
			sum_q <= sum_q + SUM_W'(sq_s1);
		end
	end

	// Element buffer, registered read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[count_q[ADDR_W-1:0]] <= in_raw;
		end
		rdata_q <= mem[rd_idx_q];
	end

	// Scale by magnitude; negative results round toward minus infinity
	assign rd_neg  = rdata_q[GRAD_W-1];
	assign rd_mag  = rd_neg ? (~rdata_q + 1'b1) : rdata_q;
	assign prod    = PROD_W'(rd_mag) * PROD_W'(calc_stat.scale);
	assign prod_hi = prod[PROD_W-1 -: GRAD_W]
		+ GRAD_W'(rd_neg && (prod[SCALE_W-1:0] != '0));
	assign scaled  = rd_neg ? (~prod_hi + 1'b1) : prod_hi;

	// Output register
	always_ff @(posedge clk) begin
		if (emit_load) begin
			grad_q <= calc_stat.clip ? scaled : rdata_q;
			last_q <= emit_last;
			clip_q <= calc_stat.clip;
		end
	end

	gnc_norm_scale u_norm_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (calc_start),
		.sum      (sum_q),
		.thr      (thr_q),
		.stat     (calc_stat)
	);

	assign out_valid = out_valid_q;
	assign grad_out  = $signed(grad_q);
	assign last_out  = last_q;
	assign clipped   = clip_q;

	`GNC_ASSERT(a_count_max, (count_q <= CNT_W'(MAX_ELEMENTS)), "element count past buffer depth")
	`GNC_ASSERT(a_rd_in_set, ((state_q == ST_LD) |-> (CNT_W'(rd_idx_q) < count_q)), "read beyond set")
	`GNC_ASSERT_NEXT(a_end_stops_in, (in_acc && end_set), !in_ready, "input taken after set end")

endmodule

// ===== verif/tb_gradient_norm_clip_core.sv =====
// Self-checking testbench for gradient_norm_clip_core: random valid/ready traffic,
// threshold sweeps and a scoreboard that predicts the clipped set per beat.
// Depends on gnc_pkg and the gradient_norm_clip_core RTL.
module tb_gradient_norm_clip_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GW          = gnc_pkg::GRAD_W;
	localparam int NW          = gnc_pkg::NORM_W;
	localparam int SET_MAX     = gnc_pkg::MAX_ELEMENTS;
	localparam int SETTLE_CYC  = 50;
	localparam int HOLD_CYC    = 400;
	localparam int PHASE_BEATS = 62;

	// One expected output beat
	typedef struct packed {
		logic signed [GW-1:0] grad;
		logic                 last;
		logic                 clip;
	} clip_beat_t;

	// Scoreboard: mirrors buffer, sum of squares and threshold, queues the set
	class clip_scoreboard;
		logic [NW-1:0]        threshold;
		logic signed [GW-1:0] set_elems[$];
		logic [36:0]          sq_sum;
		clip_beat_t           expected_beats[$];
		int                   errors;
		int                   sets_done;
		int                   clipped_sets;
		int                   beats_checked;

		function new();
			threshold     = gnc_pkg::THR_RST;
			sq_sum        = '0;
			errors        = 0;
			sets_done     = 0;
			clipped_sets  = 0;
			beats_checked = 0;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// floor(sqrt(v)) by greedy bit setting; the root fits in 19 bits
		function longint unsigned floor_root(longint unsigned v);
			longint unsigned root;
			longint unsigned probe;
			root = 0;
			for (int b = 19; b >= 0; b--) begin
				probe = root | (64'd1 << b);
				if (probe * probe <= v)
					root = probe;
			end
			return root;
		endfunction

		// (grad * scale) >> 16 with the shift rounding toward minus infinity
		function logic signed [GW-1:0] apply_scale(logic signed [GW-1:0] e,
				longint unsigned scale);
			longint prod;
			prod = longint'(e) * longint'(scale);
			return prod[31:16];
		endfunction

		// Accepted input beat: accumulate, and on the end of a set queue its results
		function void note_input(logic signed [GW-1:0] g, logic last);
			longint          gs;
			longint unsigned mag;
			longint unsigned norm;
			longint unsigned scale;
			logic            clip;
			clip_beat_t      beat;
			int              n;
			gs  = g;
			mag = (gs < 0) ? -gs : gs;
			set_elems.push_back(g);
			sq_sum = sq_sum + 37'(mag * mag);
			if (!last && set_elems.size() < SET_MAX)
				return;
			norm  = floor_root(longint'(sq_sum));
			clip  = norm > longint'(threshold);
			scale = clip ? ((longint'(threshold) << 16) / norm) : 0;
			n     = set_elems.size();
			for (int k = 0; k < n; k++) begin
				beat.grad = clip ? apply_scale(set_elems[k], scale) : set_elems[k];
				beat.last = (k == n - 1);
				beat.clip = clip;
				expected_beats.push_back(beat);
			end
			sets_done++;
			if (clip)
				clipped_sets++;
			set_elems.delete();
			sq_sum = '0;
		endfunction

		// Accepted output beat: compare with the oldest expectation
		function void check_result(logic signed [GW-1:0] g, logic last, logic clip);
			clip_beat_t exp_beat;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat grad=%0d last=%b clipped=%b",
					$time, g, last, clip);
				errors++;
				return;
			end
			exp_beat = expected_beats.pop_front();
			beats_checked++;
			if (g !== exp_beat.grad) begin
				$display("%0t: grad_out expected %0d actual %0d", $time, exp_beat.grad, g);
				errors++;
			end
			if (last !== exp_beat.last) begin
				$display("%0t: last_out expected %b actual %b", $time, exp_beat.last, last);
				errors++;
			end
			if (clip !== exp_beat.clip) begin
				$display("%0t: clipped expected %b actual %b", $time, exp_beat.clip, clip);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [NW-1:0]        cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [GW-1:0] grad_in = '0;
	logic                 last_in = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [GW-1:0] grad_out;
	logic                 last_out;
	logic                 clipped;

	clip_scoreboard sb;
	bit             no_idle = 1'b0;
	bit             hold_request = 1'b0;
	int             beats_sent = 0;
	int             thresholds_used = 0;

	gradient_norm_clip_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.grad_in   (grad_in),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.grad_out  (grad_out),
		.last_out  (last_out),
		.clipped   (clipped)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Gradient value: extremes, full-range and moderate magnitudes
	function automatic logic signed [GW-1:0] pick_grad();
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: v = -32768;
				1: v = 32767;
				2: v = -1;
				3: v = 1;
				default: v = 0;
			endcase
		end else if (r < 4) begin
			v = $urandom;
		end else begin
			v = int'($urandom_range(0, 8191)) - 4096;
		end
		return GW'(v);
	endfunction

	// Set length: mostly short, some medium, a few that fill the buffer
	function automatic int pick_set_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return SET_MAX;
		if (r < 15)
			return $urandom_range(9, SET_MAX - 1);
		return $urandom_range(1, 8);
	endfunction

	// Offer one beat and wait for its handshake
	task automatic send_beat(input logic signed [GW-1:0] g, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		grad_in  <= g;
		last_in  <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(g, last);
		beats_sent++;
	endtask

	// Stop offering and wait until every expected beat has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [NW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.threshold = v;
		thresholds_used++;
	endtask

	// Random sets under one threshold
	task automatic random_phase(input logic [NW-1:0] thr);
		int   sent;
		int   len;
		logic last;
		set_threshold(thr);
		sent = 0;
		while (sent < PHASE_BEATS) begin
			len = pick_set_len();
			for (int k = 0; k < len; k++) begin
				last = (k == len - 1);
				// a full buffer ends the set whatever last_in says
				if (len == SET_MAX && k == len - 1)
					last = 1'($urandom_range(0, 1));
				send_beat(pick_grad(), last);
			end
			sent += len;
		end
		drain();
	endtask

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end else begin
					out_ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(grad_out, last_out, clipped);
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Timeout at %0t, %0d beats still expected", $time, sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Main sequence
	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Threshold after reset: norm equal to it, just above it, extremes
		send_beat(16'sd4096, 1'b1);
		send_beat(16'sd4097, 1'b1);
		send_beat(-16'sd32768, 1'b0);
		send_beat(16'sd32767, 1'b1);
		send_beat(-16'sd1, 1'b0);
		send_beat(16'sd1, 1'b0);
		send_beat(16'sd0, 1'b0);
		send_beat(-16'sd5, 1'b1);
		drain();

		// Zero threshold: everything nonzero clips to zero, an all-zero set passes
		set_threshold('0);
		send_beat(-16'sd3, 1'b0);
		send_beat(16'sd5, 1'b1);
		send_beat(16'sd0, 1'b1);
		send_beat(-16'sd32768, 1'b1);
		drain();

		// Largest threshold: nothing clips
		set_threshold({NW{1'b1}});
		for (int k = 0; k < 3; k++)
			send_beat(-16'sd32768, 1'b0);
		send_beat(16'sd32767, 1'b1);
		drain();

		// Random part
		random_phase('0);
		hold_request = 1'b1;
		random_phase({NW{1'b1}});
		random_phase(NW'($urandom_range(1, 6000)));
		no_idle = 1'b1;
		random_phase(NW'($urandom_range(6000, 250000)));
		no_idle = 1'b0;
		random_phase(NW'($urandom));

		$display("Sent %0d beats in %0d sets under %0d thresholds; %0d sets clipped.",
			beats_sent, sb.sets_done, thresholds_used + 1, sb.clipped_sets);
		$display("Checked %0d output beats, %0d mismatches.", sb.beats_checked, sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
